// ===== hdl/ppwd_pkg.sv =====
// shared types, constants and helpers for the pinhole projection block
package ppwd_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned ProdW    = 49;
  localparam int unsigned AccW     = 51;
  localparam int unsigned CamW     = 37;
  localparam int unsigned NumW     = 53;
  localparam int unsigned QuoW     = 32;
  localparam int unsigned CmpW     = 69;
  localparam int unsigned RegW     = 64;
  localparam int unsigned AddrW    = 6;

  typedef enum logic [2:0] {
    REG_ROT_A      = 3'd0,
    REG_ROT_B      = 3'd1,
    REG_ROT_C      = 3'd2,
    REG_CAM_X      = 3'd3,
    REG_CAM_Y      = 3'd4,
    REG_CAM_Z      = 3'd5,
    REG_INTRINSICS = 3'd6,
    REG_DISTORTION = 3'd7
  } reg_idx_t;

  localparam logic [47:0] RotAReset  = 48'h0000_0000_4000;
  localparam logic [47:0] RotBReset  = 48'h0000_4000_0000;
  localparam logic [47:0] RotCReset  = 48'h4000_0000_0000;
  localparam logic [63:0] IntrReset  = 64'h0F00_1400_12C0_12C0;

  // clamp a signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ===== hdl/ppwd_if.sv =====
// item channels for world points and projected pixels
interface ppwd_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;
  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

interface ppwd_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] pixel_x;
  logic signed [31:0] pixel_y;
  logic signed [31:0] cam_depth;
  logic              zero_depth;
  modport source (output valid, pixel_x, pixel_y, cam_depth, zero_depth, input ready);
  modport sink (input valid, pixel_x, pixel_y, cam_depth, zero_depth, output ready);
endinterface

// ===== hdl/ppwd_div.sv =====
// pipelined signed divide of -num*2^16 by den, one quotient bit per stage, saturated
module ppwd_div (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [ppwd_pkg::CamW-1:0]     num,
  input  logic signed [ppwd_pkg::CamW-1:0]     den,
  output logic signed [31:0]                   quo
);
  import ppwd_pkg::*;

  logic [NumW-1:0] rem  [QuoW+1];
  logic [CamW-1:0] dmag [QuoW+1];
  logic [QuoW-1:0] qacc [QuoW+1];
  logic            neg  [QuoW+1];
  logic            ovf  [QuoW+1];

  logic [CamW-1:0] nabs;
  logic [CamW-1:0] dabs;
  logic [NumW-1:0] nsh;

  always_comb begin
    nabs = num[CamW-1] ? CamW'(-num) : CamW'(num);
    dabs = den[CamW-1] ? CamW'(-den) : CamW'(den);
    nsh  = {nabs[NumW-17:0], 16'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= nsh;
      dmag[0] <= dabs;
      qacc[0] <= '0;
      neg[0]  <= (num > 0) ^ den[CamW-1];
      ovf[0]  <= {16'b0, nsh} >= {dabs, 32'b0};
    end
  end

  for (genvar i = 0; i < QuoW; i++) begin : g_stage
    localparam int unsigned Sh = QuoW - 1 - i;
    logic [CmpW-1:0] dsh;
    logic            take;
    always_comb begin
      dsh  = CmpW'(dmag[i]) << Sh;
      take = {16'b0, rem[i]} >= dsh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= take ? NumW'(rem[i] - dsh[NumW-1:0]) : rem[i];
        dmag[i+1] <= dmag[i];
        qacc[i+1] <= qacc[i] | (take ? (QuoW'(1) << Sh) : '0);
        neg[i+1]  <= neg[i];
        ovf[i+1]  <= ovf[i];
      end
    end
  end

  always_comb begin
    if (!neg[QuoW]) begin
      quo = (ovf[QuoW] || qacc[QuoW][31]) ? 32'sh7FFF_FFFF : $signed(qacc[QuoW]);
    end else begin
      quo = (ovf[QuoW] || (qacc[QuoW] > 32'h8000_0000)) ? 32'sh8000_0000
            : $signed(-qacc[QuoW]);
    end
  end

endmodule

// ===== hdl/pinhole_projection_with_distortion.sv =====
// pinhole projection with radial and tangential lens distortion, fixed point
// throughput: one item per cycle; the 32-stage quotient pipeline sets the depth
// a full output register that is not taken holds the whole pipeline
// reset: synchronous, clears valid, camera, distortion; sets identity rotation, default intrinsics
module pinhole_projection_with_distortion (
  input  logic                          clk,
  input  logic                          rst,
  ppwd_in_if.sink                       in_ch,
  ppwd_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppwd_pkg::AddrW-1:0]    paddr,
  input  logic [ppwd_pkg::RegW-1:0]     pwdata,
  output logic [ppwd_pkg::RegW-1:0]     prdata,
  output logic                          pready
);
  import ppwd_pkg::*;

  localparam int unsigned PipeLen = 47;
  localparam int unsigned SbLen   = 43;

  typedef struct packed {
    logic              zero;
    logic signed [31:0] depth;
  } side_t;

  // configuration
  logic [47:0] rot [3];
  logic signed [31:0] cam [3];
  logic [63:0] intr;
  logic [63:0] distort;
  reg_idx_t    widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0]  <= RotAReset;
      rot[1]  <= RotBReset;
      rot[2]  <= RotCReset;
      cam[0]  <= '0;
      cam[1]  <= '0;
      cam[2]  <= '0;
      intr    <= IntrReset;
      distort <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_ROT_A:      rot[0]  <= pwdata[47:0];
        REG_ROT_B:      rot[1]  <= pwdata[47:0];
        REG_ROT_C:      rot[2]  <= pwdata[47:0];
        REG_CAM_X:      cam[0]  <= pwdata[31:0];
        REG_CAM_Y:      cam[1]  <= pwdata[31:0];
        REG_CAM_Z:      cam[2]  <= pwdata[31:0];
        REG_INTRINSICS: intr    <= pwdata;
        REG_DISTORTION: distort <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_ROT_A:      prdata = {16'b0, rot[0]};
      REG_ROT_B:      prdata = {16'b0, rot[1]};
      REG_ROT_C:      prdata = {16'b0, rot[2]};
      REG_CAM_X:      prdata = {32'b0, cam[0]};
      REG_CAM_Y:      prdata = {32'b0, cam[1]};
      REG_CAM_Z:      prdata = {32'b0, cam[2]};
      REG_INTRINSICS: prdata = intr;
      REG_DISTORTION: prdata = distort;
      default:        prdata = '0;
    endcase
  end

  logic signed [15:0] k1, k2, p1, p2;
  logic [15:0] fx, fy, cx, cy;
  assign k1 = distort[15:0];
  assign k2 = distort[31:16];
  assign p1 = distort[47:32];
  assign p2 = distort[63:48];
  assign fx = intr[15:0];
  assign fy = intr[31:16];
  assign cx = intr[47:32];
  assign cy = intr[63:48];

  // pipeline control
  logic [PipeLen:1] vld;
  logic             adv;

  assign adv          = !vld[PipeLen] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld[PipeLen];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PipeLen-1:1], in_ch.valid};
    end
  end

  // stage 1: offset from camera
  logic signed [DiffW-1:0] dif [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      dif[0] <= DiffW'(in_ch.world_x) - DiffW'(cam[0]);
      dif[1] <= DiffW'(in_ch.world_y) - DiffW'(cam[1]);
      dif[2] <= DiffW'(in_ch.world_z) - DiffW'(cam[2]);
    end
  end

  // stage 2: rotation products
  logic signed [ProdW-1:0] prd [3][3];
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [CoefW-1:0] coef;
      assign coef = rot[r][16*c +: 16];
      always_ff @(posedge clk) begin
        if (adv) prd[r][c] <= coef * dif[c];
      end
    end
  end

  // stage 3: row sums into camera frame
  logic signed [AccW-1:0] acc [3];
  logic signed [CamW-1:0] xc, yc, zc;
  side_t                  sb [SbLen];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AccW'(prd[r][0]) + AccW'(prd[r][1]) + AccW'(prd[r][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xc <= acc[0][AccW-1-:CamW];
      yc <= acc[1][AccW-1-:CamW];
      zc <= acc[2][AccW-1-:CamW];
    end
  end

  // depth side data rides alongside the divider and the distortion math
  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0].zero  <= (zc == '0);
      sb[0].depth <= sat32(64'(zc));
      for (int i = 1; i < SbLen; i++) sb[i] <= sb[i-1];
    end
  end

  // stages 4 to 36: normalized coordinates
  logic signed [31:0] uq, vq;
  ppwd_div u_div_u (.clk(clk), .en(adv), .num(xc), .den(zc), .quo(uq));
  ppwd_div u_div_v (.clk(clk), .en(adv), .num(yc), .den(zc), .quo(vq));

  // stages 37 onward: distortion and intrinsics
  logic signed [31:0] u37, v37, u38, v38, u39, v39, u40, v40, u41, v41, u42, v42, u43, v43;
  logic signed [63:0] uup, vvp, uvp;
  logic signed [31:0] r2, uu, vv, uv, uvc, r4;
  logic        [61:0] r4p;
  logic signed [47:0] k1r2, k1r2d, k1r2e, k2r4;
  logic signed [33:0] su, sv;
  logic signed [48:0] p1uv2, p2uv2;
  logic signed [49:0] p2su, p1sv;
  logic signed [50:0] tu, tv;
  logic signed [31:0] g;
  logic signed [36:0] tus, tvs, tus_g;
  logic signed [36:0] tvs_g;
  logic signed [63:0] gu, gv;
  logic signed [31:0] ud, vd;
  logic signed [48:0] prx, pry;

  logic [63:0] sq;
  logic signed [49:0] gs;
  logic signed [48:0] usum, vsum;
  logic signed [49:0] pxs, pys;

  always_comb begin
    sq   = 64'(uup + vvp) >> 16;
    gs   = 50'sh0_4000_0000 + 50'(k1r2e) + 50'(k2r4);
    usum = 49'(gu >>> 16) + 49'(tus_g);
    vsum = 49'(gv >>> 16) + 49'(tvs_g);
    pxs  = ((-50'(prx)) >>> 4) + 50'($signed({1'b0, cx, 12'b0}));
    pys  = ((-50'(pry)) >>> 4) + 50'($signed({1'b0, cy, 12'b0}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // 37
      u37 <= uq;
      v37 <= vq;
      // 38: squares and cross term
      uup <= u37 * u37;
      vvp <= v37 * v37;
      uvp <= u37 * v37;
      u38 <= u37;
      v38 <= v37;
      // 39: scaled radius and products
      r2  <= (sq > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(sq[31:0]);
      uu  <= sat32(uup >>> 16);
      vv  <= sat32(vvp >>> 16);
      uv  <= sat32(uvp >>> 16);
      u39 <= u38;
      v39 <= v38;
      // 40
      r4p  <= 62'(r2 * r2);
      k1r2 <= k1 * r2;
      su   <= 34'(r2) + (34'(uu) <<< 1);
      sv   <= 34'(r2) + (34'(vv) <<< 1);
      uvc  <= uv;
      u40  <= u39;
      v40  <= v39;
      // 41
      r4    <= (r4p[61:16] > 46'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r4p[47:16]);
      p1uv2 <= 49'(p1 * uvc) <<< 1;
      p2uv2 <= 49'(p2 * uvc) <<< 1;
      p2su  <= p2 * su;
      p1sv  <= p1 * sv;
      k1r2d <= k1r2;
      u41   <= u40;
      v41   <= v40;
      // 42
      k2r4  <= k2 * r4;
      tu    <= 51'(p1uv2) + 51'(p2su);
      tv    <= 51'(p1sv) + 51'(p2uv2);
      k1r2e <= k1r2d;
      u42   <= u41;
      v42   <= v41;
      // 43: radial gain
      g   <= sat32(64'(gs >>> 14));
      tus <= 37'(tu >>> 14);
      tvs <= 37'(tv >>> 14);
      u43 <= u42;
      v43 <= v42;
      // 44
      gu    <= g * u43;
      gv    <= g * v43;
      tus_g <= tus;
      tvs_g <= tvs;
      // 45
      ud <= sat32(64'(usum));
      vd <= sat32(64'(vsum));
      // 46
      prx <= ud * $signed({1'b0, fx});
      pry <= vd * $signed({1'b0, fy});
      // 47: output register
      out_ch.zero_depth <= sb[SbLen-1].zero;
      out_ch.cam_depth  <= sb[SbLen-1].zero ? '0 : sb[SbLen-1].depth;
      out_ch.pixel_x    <= sb[SbLen-1].zero ? '0 : sat32(64'(pxs));
      out_ch.pixel_y    <= sb[SbLen-1].zero ? '0 : sat32(64'(pys));
    end
  end

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.zero_depth |->
      out_ch.pixel_x == 0 && out_ch.pixel_y == 0 && out_ch.cam_depth == 0)
    else $error("zero depth item carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> vld[1])
    else $error("accepted item lost at pipeline entry");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved during a stall");

endmodule
